// ===== rtl/sdts_pkg.sv =====
// Package for the squared distance threshold select unit.
// Holds widths, register indexes and the structs shared between modules.
// No dependencies.
`timescale 1ns / 1ps

package sdts_pkg;

   localparam int VALUE_W            = 16;
   localparam int DIFF_W             = VALUE_W + 1;
   localparam int SQ_W               = 2 * VALUE_W + 1;
   localparam int DIST_W             = 48;
   localparam int OUT_COUNT_W        = 24;
   localparam int COUNT_BITS_DEFAULT = 24;

   localparam int REQ_DATA_W = 2 * VALUE_W;
   localparam int RSP_DATA_W = DIST_W + 2 * OUT_COUNT_W;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Register index, taken from paddr[4:3] (registers lie on 8-byte steps).
   typedef enum logic [1:0] {
      REG_THRESHOLD    = 2'd0,
      REG_LIMIT_ENABLE = 2'd1,
      REG_RETAIN_LIMIT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [DIST_W-1:0]      distance_threshold;
      logic                   limit_enable;
      logic [OUT_COUNT_W-1:0] retain_limit;
   } cfg_type;

   typedef struct packed {
      logic [SQ_W-1:0] square;
      logic            last_stat;
   } sq_beat_type;

endpackage

// ===== rtl/sdts_csr.sv =====
// Configuration registers of the squared distance threshold select unit.
// APB-style write and read access. Depends on sdts_pkg.
`timescale 1ns / 1ps

module sdts_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [sdts_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [sdts_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [sdts_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output sdts_pkg::cfg_type                   cfg
);

   sdts_pkg::cfg_type       cfg_ff, cfg_in;
   sdts_pkg::reg_index_type index;
   logic                    write_strobe;

   assign csr_pready   = 1'b1;
   assign index        = sdts_pkg::reg_index_type'(csr_paddr[4:3]);
   assign write_strobe = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (index)
            sdts_pkg::REG_THRESHOLD:
               cfg_in.distance_threshold = csr_pwdata[sdts_pkg::DIST_W-1:0];
            sdts_pkg::REG_LIMIT_ENABLE:
               cfg_in.limit_enable = csr_pwdata[0];
            sdts_pkg::REG_RETAIN_LIMIT:
               cfg_in.retain_limit = csr_pwdata[sdts_pkg::OUT_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (index)
         sdts_pkg::REG_THRESHOLD:
            csr_prdata[sdts_pkg::DIST_W-1:0] = cfg_ff.distance_threshold;
         sdts_pkg::REG_LIMIT_ENABLE:
            csr_prdata[0] = cfg_ff.limit_enable;
         sdts_pkg::REG_RETAIN_LIMIT:
            csr_prdata[sdts_pkg::OUT_COUNT_W-1:0] = cfg_ff.retain_limit;
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/sdts_square.sv =====
// Input register and squared-difference stage.
// Registers the incoming beat, then registers (sim - obs)^2. Depends on sdts_pkg.
`timescale 1ns / 1ps

module sdts_square (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic signed [sdts_pkg::VALUE_W-1:0] in_sim,
   input  logic signed [sdts_pkg::VALUE_W-1:0] in_obs,
   input  logic                               in_last,
   output logic                               out_valid,
   input  logic                               out_ready,
   output sdts_pkg::sq_beat_type              out_beat
);

   logic                                 in_valid_ff, in_valid_in;
   logic signed [sdts_pkg::VALUE_W-1:0]  sim_ff, obs_ff;
   logic                                 last_in_ff;
   logic                                 sq_valid_ff, sq_valid_in;
   sdts_pkg::sq_beat_type                sq_ff, sq_in;
   logic signed [sdts_pkg::DIFF_W-1:0]   diff;
   logic signed [2*sdts_pkg::DIFF_W-1:0] product;
   logic                                 sq_load;
   logic                                 in_load;

   function automatic logic signed [sdts_pkg::DIFF_W-1:0] in_sim_ext(
      input logic signed [sdts_pkg::VALUE_W-1:0] v
   );
      in_sim_ext = {v[sdts_pkg::VALUE_W-1], v};
   endfunction

   // A stage loads when it is empty or its content moves on in this cycle.
   assign sq_load  = !sq_valid_ff || out_ready;
   assign in_load  = !in_valid_ff || sq_load;
   assign in_ready = in_load;

   assign diff    = sdts_pkg::DIFF_W'(in_sim_ext(sim_ff))
                  - sdts_pkg::DIFF_W'(in_sim_ext(obs_ff));
   assign product = diff * diff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_load) begin
         in_valid_in = in_valid;
      end
      sq_valid_in = sq_valid_ff;
      sq_in       = sq_ff;
      if (sq_load) begin
         sq_valid_in     = in_valid_ff;
         sq_in.square    = product[sdts_pkg::SQ_W-1:0];
         sq_in.last_stat = last_in_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         sim_ff     <= in_sim;
         obs_ff     <= in_obs;
         last_in_ff <= in_last;
      end
      sq_ff <= sq_in;
   end

   assign out_valid = sq_valid_ff;
   assign out_beat  = sq_ff;

endmodule

// ===== rtl/sdts_select.sv =====
// Accumulator, threshold and limit decision, counters and result register.
// Consumes squared differences and delivers one result per simulation.
// Depends on sdts_pkg.
`timescale 1ns / 1ps

module sdts_select #(
   parameter int COUNT_BITS = sdts_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sdts_pkg::cfg_type                     cfg,
   input  logic                                  sq_valid,
   output logic                                  sq_ready,
   input  sdts_pkg::sq_beat_type                 sq_beat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sdts_pkg::DIST_W-1:0]           rsp_distance,
   output logic [sdts_pkg::OUT_COUNT_W-1:0]      rsp_sim_number,
   output logic                                  rsp_retained,
   output logic [sdts_pkg::OUT_COUNT_W-1:0]      rsp_retained_total
);

   localparam int CMP_W = (COUNT_BITS > sdts_pkg::OUT_COUNT_W) ?
                          COUNT_BITS : sdts_pkg::OUT_COUNT_W;

   logic [sdts_pkg::DIST_W-1:0]      acc_ff, acc_in;
   logic [COUNT_BITS-1:0]            sim_count_ff, sim_count_in;
   logic [COUNT_BITS-1:0]            kept_count_ff, kept_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sdts_pkg::DIST_W-1:0]      dist_ff, dist_in;
   logic [sdts_pkg::OUT_COUNT_W-1:0] sim_num_ff, sim_num_in;
   logic                             kept_ff, kept_in;
   logic [sdts_pkg::OUT_COUNT_W-1:0] total_ff, total_in;

   logic [sdts_pkg::DIST_W:0]        sum;
   logic [sdts_pkg::DIST_W-1:0]      sum_sat;
   logic [CMP_W-1:0]                 kept_ext, limit_ext, kept_next_ext, sim_ext;
   logic [COUNT_BITS-1:0]            kept_next;
   logic                             limit_hit;
   logic                             keep;
   logic                             consume;

   // Beats that do not close a simulation never need the result register.
   assign sq_ready = !sq_beat.last_stat || !rsp_valid_ff || rsp_ready;
   assign consume  = sq_valid && sq_ready;

   assign sum     = {1'b0, acc_ff} + (sdts_pkg::DIST_W + 1)'(sq_beat.square);
   assign sum_sat = sum[sdts_pkg::DIST_W] ? '1 : sum[sdts_pkg::DIST_W-1:0];

   assign kept_ext  = CMP_W'(kept_count_ff);
   assign limit_ext = CMP_W'(cfg.retain_limit);
   assign limit_hit = cfg.limit_enable && (kept_ext >= limit_ext);
   assign keep      = (sum_sat <= cfg.distance_threshold) && !limit_hit;

   // The retained count saturates at all ones.
   assign kept_next     = (keep && !(&kept_count_ff)) ? kept_count_ff + 1'b1 : kept_count_ff;
   assign kept_next_ext = CMP_W'(kept_next);
   assign sim_ext       = CMP_W'(sim_count_ff);

   always_comb begin
      acc_in        = acc_ff;
      sim_count_in  = sim_count_ff;
      kept_count_in = kept_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      dist_in       = dist_ff;
      sim_num_in    = sim_num_ff;
      kept_in       = kept_ff;
      total_in      = total_ff;
      if (consume) begin
         if (sq_beat.last_stat) begin
            acc_in        = '0;
            sim_count_in  = sim_count_ff + 1'b1;
            kept_count_in = kept_next;
            rsp_valid_in  = 1'b1;
            dist_in       = sum_sat;
            sim_num_in    = sim_ext[sdts_pkg::OUT_COUNT_W-1:0];
            kept_in       = keep;
            total_in      = kept_next_ext[sdts_pkg::OUT_COUNT_W-1:0];
         end else begin
            acc_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         sim_count_ff  <= '0;
         kept_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         sim_count_ff  <= sim_count_in;
         kept_count_ff <= kept_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff    <= dist_in;
      sim_num_ff <= sim_num_in;
      kept_ff    <= kept_in;
      total_ff   <= total_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance       = dist_ff;
   assign rsp_sim_number     = sim_num_ff;
   assign rsp_retained       = kept_ff;
   assign rsp_retained_total = total_ff;

endmodule

// ===== rtl/squared_distance_threshold_select_unit.sv =====
// Squared distance threshold select unit: accumulates (sim - obs)^2 per simulation and
// decides retention against a threshold and an optional retain limit.
// Throughput: one statistic beat per cycle, sustained unless a result beat is stalled.
// Path: a closing beat passes the input, square and result registers in turn.
// Reset: synchronous, active high; clears config registers, accumulator and both counters.
// Depends on sdts_pkg, sdts_csr, sdts_square and sdts_select.
`timescale 1ns / 1ps

module squared_distance_threshold_select_unit #(
   parameter int COUNT_BITS = sdts_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: sim_value [15:0], obs_value [31:16]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [sdts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tlast,
   // tdata: distance [47:0], sim_number [71:48], retained_total [95:72]
   // tuser: retained [0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [sdts_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                 rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sdts_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [sdts_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [sdts_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   sdts_pkg::cfg_type                cfg;
   logic                             sq_valid;
   logic                             sq_ready;
   sdts_pkg::sq_beat_type            sq_beat;
   logic [sdts_pkg::DIST_W-1:0]      distance;
   logic [sdts_pkg::OUT_COUNT_W-1:0] sim_number;
   logic [sdts_pkg::OUT_COUNT_W-1:0] retained_total;

   sdts_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sdts_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_sim    (req_tdata[sdts_pkg::VALUE_W-1:0]),
      .in_obs    (req_tdata[2*sdts_pkg::VALUE_W-1:sdts_pkg::VALUE_W]),
      .in_last   (req_tlast),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_beat  (sq_beat)
   );

   sdts_select #(
      .COUNT_BITS (COUNT_BITS)
   ) u_select (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .sq_valid           (sq_valid),
      .sq_ready           (sq_ready),
      .sq_beat            (sq_beat),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_distance       (distance),
      .rsp_sim_number     (sim_number),
      .rsp_retained       (rsp_tuser),
      .rsp_retained_total (retained_total)
   );

   assign rsp_tdata = {retained_total, sim_number, distance};

endmodule

// ===== rtl/sdts_checker.sv =====
// Port-level checks for the squared distance threshold select unit,
// bound to the top level. Depends on sdts_pkg.
`timescale 1ns / 1ps

module sdts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sdts_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);

   localparam int TOTAL_LO = sdts_pkg::DIST_W + sdts_pkg::OUT_COUNT_W;

   // Reset leaves no result beat pending.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat valid right after reset");

   // With the result register empty, the pipeline always has room for a beat.
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled while result register is empty");

   // A retained simulation has been counted, so the total cannot be zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[sdts_pkg::RSP_DATA_W-1:TOTAL_LO] != '0))
      else $error("retained simulation with zero retained total");

   // A stalled result beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

endmodule

bind squared_distance_threshold_select_unit sdts_checker u_sdts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
